// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/swdd_pkg.sv =====
// ----------------------------------------------------------------------------
// swdd_pkg
// Shared types and constants of the sliding-window distinct detector.
// ----------------------------------------------------------------------------
package swdd_pkg;

    localparam int CFG_W = 5;
    localparam int POS_W = 32;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 5'd4;

    // Depth of the queue between front and back; power of two, at least 2.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

// ===== hw/rtl/sliding_window_distinct_detect_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_distinct_detect_core
// Finds the first byte position where the last window_len bytes all differ.
// ----------------------------------------------------------------------------
// The core takes one byte per beat and reports, once per stream, the 1-based
// position of the first byte that closes a window of window_len distinct
// bytes (found = 1), or the position of the stream's last byte when no such
// window came (found = 0). Bytes after a report produce nothing until a beat
// with restart set opens a new stream; restart takes effect before its own
// byte is used. The position saturates at all ones. window_len is clamped to
// 1..WINDOW_MAX and is latched on the first byte of each stream, so write it
// only while the core is idle. Sustained rate is one byte per clock unless
// back-pressure fills the queue: the back part compares each byte against a
// WINDOW_MAX-deep history shift line combinationally, and the distinct-run
// length it keeps replaces a per-symbol count table, so no table needs
// clearing on restart. A byte waits in the queue and its result in the
// result register. A four-beat queue parts the input and the detector, so
// the input keeps taking bytes while a result waits on the master side; once
// the queue holds four beats, s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module sliding_window_distinct_detect_core #(
    parameter int WINDOW_MAX = 16,
    parameter int ALPHABET   = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration: window_len
    input  logic                        cfg_wr_en,
    input  logic [swdd_pkg::CFG_W-1:0]  cfg_wr_data,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] symbol
    input  logic                        s_tuser,  // [0] restart
    input  logic                        s_tlast,  // final_byte
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // [31:0] position
    output logic                        m_tuser   // [0] found
);
    import swdd_pkg::*;

    localparam int SYM_W   = $clog2(ALPHABET);
    localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
    localparam int ENTRY_W = SYM_W + LEN_W + 2;

    queue_status_t      q_status;
    logic               q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_pop_data;
    result_t            result;

    // Front: hold the register, reduce the symbol, push the beat.
    swdd_front #(
        .WINDOW_MAX (WINDOW_MAX),
        .ALPHABET   (ALPHABET)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_symbol    (s_tdata),
        .s_restart   (s_tuser),
        .s_final     (s_tlast),
        .q_status    (q_status),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    // Queue: decouple front stalls from result back-pressure.
    swdd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // Back: advance the distinct run, count bytes, emit the report.
    swdd_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .ALPHABET   (ALPHABET)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .entry_data (q_pop_data),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result)
    );

    assign m_tdata = result.position;
    assign m_tuser = result.found;

endmodule

// ===== hw/rtl/swdd_front.sv =====
// ----------------------------------------------------------------------------
// swdd_front
// Input side: holds the window length register, reduces the symbol and
// pushes each accepted beat into the queue with its stream flags.
// ----------------------------------------------------------------------------
module swdd_front #(
    parameter  int WINDOW_MAX = 16,
    parameter  int ALPHABET   = 256,
    localparam int SYM_W      = $clog2(ALPHABET),
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1),
    localparam int ENTRY_W    = SYM_W + LEN_W + 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [swdd_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_symbol,
    input  logic                        s_restart,
    input  logic                        s_final,
    input  swdd_pkg::queue_status_t     q_status,
    output logic                        push,
    output logic [ENTRY_W-1:0]          push_data
);
    import swdd_pkg::*;

    // Residue of every byte value, built at elaboration.
    function automatic logic [256*SYM_W-1:0] build_mod_tab();
        logic [256*SYM_W-1:0] tab;
        tab = '0;
        for (int i = 0; i < 256; i++) begin
            tab[i*SYM_W +: SYM_W] = SYM_W'(i % ALPHABET);
        end
        return tab;
    endfunction

    localparam logic [256*SYM_W-1:0] MOD_TAB = build_mod_tab();

    logic [CFG_W-1:0] window_len_reg;
    logic [CFG_W-1:0] window_len_next;
    logic [LEN_W-1:0] eff_len;
    logic [SYM_W-1:0] sym_red;

    always_comb begin
        window_len_next = cfg_wr_en ? cfg_wr_data : window_len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RESET;
        end else begin
            window_len_reg <= window_len_next;
        end
    end

    // Clamp the window length into 1..WINDOW_MAX.
    always_comb begin
        if (window_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(window_len_reg) > WINDOW_MAX) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = LEN_W'(window_len_reg);
        end
    end

    assign sym_red   = MOD_TAB[32'(s_symbol) * SYM_W +: SYM_W];
    assign s_tready  = !q_status.full;
    assign push      = s_tvalid && s_tready;
    assign push_data = {s_final, s_restart, eff_len, sym_red};

endmodule

// ===== hw/rtl/swdd_queue.sv =====
// ----------------------------------------------------------------------------
// swdd_queue
// Small first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module swdd_queue #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  logic [WIDTH-1:0]         push_data,
    input  logic                     pop,
    output logic [WIDTH-1:0]         pop_data,
    output swdd_pkg::queue_status_t  status
);
    import swdd_pkg::*;

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg;
    logic [PTR_W:0]   rd_ptr_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + (PTR_W+1)'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + (PTR_W+1)'(1) : rd_ptr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg[PTR_W-1:0]] <= push_data;
        end
    end

    assign pop_data     = entries_reg[rd_ptr_reg[PTR_W-1:0]];
    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                          (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);

endmodule

// ===== hw/rtl/swdd_back.sv =====
// ----------------------------------------------------------------------------
// swdd_back
// Detection side: tracks the run of distinct symbols against a history
// shift line, counts bytes and drives the result register.
// ----------------------------------------------------------------------------
module swdd_back #(
    parameter  int WINDOW_MAX = 16,
    parameter  int ALPHABET   = 256,
    localparam int SYM_W      = $clog2(ALPHABET),
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1),
    localparam int ENTRY_W    = SYM_W + LEN_W + 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  swdd_pkg::queue_status_t  q_status,
    input  logic [ENTRY_W-1:0]       entry_data,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output swdd_pkg::result_t        m_result
);
    import swdd_pkg::*;

    logic [SYM_W-1:0] hist_reg [WINDOW_MAX];
    logic [LEN_W-1:0] run_reg;
    logic [LEN_W-1:0] run_next;
    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             done_reg;
    logic             done_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;

    logic [SYM_W-1:0] e_sym;
    logic [LEN_W-1:0] e_len;
    logic             e_restart;
    logic             e_final;
    logic [POS_W-1:0] cnt0;
    logic [LEN_W-1:0] run0;
    logic             done0;
    logic [LEN_W-1:0] len_use;
    logic [LEN_W-1:0] new_run;
    logic [POS_W-1:0] cnt_inc;
    logic             found;
    logic             advance;

    assign {e_final, e_restart, e_len, e_sym} = entry_data;

    // Take an entry whenever the result register is free or draining.
    assign pop = !q_status.empty && (!out_valid_reg || m_tready);

    always_comb begin
        cnt0    = e_restart ? '0 : count_reg;
        run0    = e_restart ? '0 : run_reg;
        done0   = e_restart ? 1'b0 : done_reg;
        len_use = (cnt0 == '0) ? e_len : len_reg;
        cnt_inc = (cnt0 == POS_MAX) ? cnt0 : cnt0 + POS_W'(1);

        // Extend the distinct run, or cut it at the nearest repeat inside it.
        new_run = (run0 == LEN_W'(WINDOW_MAX)) ? run0 : run0 + LEN_W'(1);
        for (int k = WINDOW_MAX; k >= 1; k--) begin
            if ((hist_reg[k-1] == e_sym) && (LEN_W'(k) <= run0)) begin
                new_run = LEN_W'(k);
            end
        end
        found   = (new_run >= len_use);
        advance = pop && !done0;
    end

    always_comb begin
        count_next     = count_reg;
        run_next       = run_reg;
        len_next       = len_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        if (pop) begin
            count_next = cnt0;
            run_next   = run0;
            done_next  = done0;
        end
        if (advance) begin
            count_next = cnt_inc;
            run_next   = new_run;
            len_next   = len_use;
            if (found || e_final) begin
                done_next          = 1'b1;
                out_valid_next     = 1'b1;
                out_next.found     = found;
                out_next.position  = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            run_reg       <= '0;
            len_reg       <= LEN_W'(WINDOW_LEN_RESET);
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            run_reg       <= run_next;
            len_reg       <= len_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (advance) begin
            hist_reg[0] <= e_sym;
            for (int i = 1; i < WINDOW_MAX; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ===== hw/rtl/swdd_checker.sv =====
// ----------------------------------------------------------------------------
// swdd_checker
// Port-level checks of the detector core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swdd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    logic [31:0] balance_reg;
    logic [31:0] balance_next;
    logic        in_beat;
    logic        out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Inputs accepted minus results taken; sticky once saturated.
    always_comb begin
        balance_next = balance_reg;
        if (balance_reg != '1) begin
            balance_next = balance_reg + 32'(in_beat) - 32'(out_beat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            balance_reg <= '0;
        end else begin
            balance_reg <= balance_next;
        end
    end

    `ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_IMPLIES(a_position_nonzero, aclk, aresetn, m_tvalid, m_tdata != 32'd0)
    `ASSERT_IMPLIES(a_result_has_byte, aclk, aresetn, m_tvalid, balance_reg != 32'd0)

endmodule

bind sliding_window_distinct_detect_core swdd_checker u_swdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/distinct_detect_checker.sv =====
// ----------------------------------------------------------------------------
// distinct_detect_checker
// Predicts and checks the result beats of the distinct-window detector.
// ----------------------------------------------------------------------------
// Watches the configuration port and both stream channels. Every accepted
// input beat runs through a per-symbol count model of the detector, and any
// result it causes is queued. Every accepted result beat is compared against
// the oldest queued result.
// ----------------------------------------------------------------------------
module distinct_detect_checker #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [swdd_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tuser,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [31:0]                 m_tdata,
    input  logic                        m_tuser,
    output int                          fail_count,
    output int                          outstanding,
    output int                          bytes_used
);
    timeunit 1ns;
    timeprecision 1ps;

    import swdd_pkg::*;

    logic [CFG_W-1:0] window_reg;
    logic [7:0]       sym_count [256];
    logic [7:0]       history [WINDOW_MAX];
    int unsigned      dup_symbols;
    logic [POS_W-1:0] stream_pos;
    logic             stream_closed;
    int unsigned      hist_slot;
    int unsigned      latched_len;
    int               errors = 0;
    int               used = 0;
    result_t          pending_results [$];

    function automatic int unsigned clamp_len(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > WINDOW_MAX)
            return WINDOW_MAX;
        return raw;
    endfunction

    function automatic void open_stream();
        foreach (sym_count[i])
            sym_count[i] = '0;
        foreach (history[i])
            history[i] = '0;
        dup_symbols   = 0;
        stream_pos    = '0;
        stream_closed = 1'b0;
        hist_slot     = 0;
        latched_len   = clamp_len(window_reg);
    endfunction

    // Returns 1 when the byte closes the stream; res then holds the report.
    function automatic bit consume_byte(input logic [7:0] sym, input logic rst,
                                        input logic fin, output result_t res);
        logic [7:0] leaving;
        res = '0;
        if (rst)
            open_stream();
        if (stream_closed)
            return 0;
        if (stream_pos == '0)
            latched_len = clamp_len(window_reg);

        sym_count[sym] = sym_count[sym] + 8'd1;
        if (sym_count[sym] == 8'd2)
            dup_symbols++;

        if (hist_slot >= latched_len)
            hist_slot = 0;
        // Once the window is full, drop the byte that falls out of it.
        if (stream_pos >= latched_len) begin
            leaving = history[hist_slot];
            sym_count[leaving] = sym_count[leaving] - 8'd1;
            if (sym_count[leaving] == 8'd1 && dup_symbols > 0)
                dup_symbols--;
        end
        history[hist_slot] = sym;
        hist_slot = (hist_slot + 1 >= latched_len) ? 0 : hist_slot + 1;

        if (stream_pos != POS_MAX)
            stream_pos = stream_pos + 1'b1;

        if (stream_pos >= latched_len && dup_symbols == 0) begin
            res.position  = stream_pos;
            res.found     = 1'b1;
            stream_closed = 1'b1;
            return 1;
        end
        if (fin) begin
            res.position  = stream_pos;
            res.found     = 1'b0;
            stream_closed = 1'b1;
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t fresh;
        if (!aresetn) begin
            window_reg = WINDOW_LEN_RESET;
            open_stream();
            pending_results.delete();
        end else begin
            if (cfg_wr_en)
                window_reg = cfg_wr_data;
            // Compare first so a stray beat cannot match a same-edge prediction.
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual pos %0d found %0b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.position) begin
                        errors++;
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, m_tdata);
                    end
                    if (m_tuser !== want.found) begin
                        errors++;
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, m_tuser);
                    end
                end
            end
            // Count every accepted input beat, ignored ones included.
            if (s_tvalid && s_tready)
                used++;
            if (s_tvalid && s_tready && consume_byte(s_tdata, s_tuser, s_tlast, fresh))
                pending_results.push_back(fresh);
        end
        fail_count  <= errors;
        outstanding <= pending_results.size();
        bytes_used  <= used;
    end

endmodule

// ===== sim/tb_sliding_window_distinct_detect_core.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_distinct_detect_core
// Stream-level test of the sliding-window distinct detector.
// ----------------------------------------------------------------------------
// Drives byte streams into the core under a series of window lengths, from a
// directed opening through randomized streams drawn from small per-stream
// symbol sets, with noise and broken streams mixed in. Both channels idle at
// random; the receiver also holds off once for a long stretch. A checker
// beside the core predicts every result and compares it beat by beat.
// ----------------------------------------------------------------------------
module tb_sliding_window_distinct_detect_core;
    timeunit 1ns;
    timeprecision 1ps;

    import swdd_pkg::*;

    localparam int WINDOW_MAX   = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RX_LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 8;   // leave slack for bytes still in flight in the core
    localparam int IDLE_PCT     = 13;
    localparam int RANDOM_BYTES = 600;
    localparam int NUM_PHASES   = 10;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata     = '0;
    logic             s_tuser     = 1'b0;
    logic             s_tlast     = 1'b0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [31:0]      m_tdata;
    logic             m_tuser;

    int fail_count;
    int outstanding;
    int bytes_used;

    // Shared knobs from the stimulus process to the receiver.
    logic        calm          = 1'b0;
    logic        rx_stall_req  = 1'b0;
    logic        rx_stall_done = 1'b0;
    int unsigned rx_hold_left  = 0;
    int unsigned cycle_count   = 0;

    sliding_window_distinct_detect_core #(
        .WINDOW_MAX (WINDOW_MAX),
        .ALPHABET   (256)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    distinct_detect_checker #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .bytes_used  (bytes_used)
    );

    always #10 aclk = ~aclk;

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result receiver: random back-pressure, one long hold-off on request,
    // and no stalls at all while calm is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_stall_req && !rx_stall_done) begin
            m_tready      <= 1'b0;
            rx_hold_left  <= RX_LONG_HOLD;
            rx_stall_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one beat, after an optional random gap, and hold it until taken.
    // tvalid stays high on return so back-to-back beats follow without a gap.
    task automatic send_byte(input logic [7:0] sym, input logic rst, input logic fin);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= rst;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait until every predicted result has come back. The
    // first edge lets the checker count the beat accepted just before.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Write window_len once the core is idle; bytes that cause no result may
    // still be in flight, so let the pipeline run dry first.
    task automatic set_window(input logic [CFG_W-1:0] len);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One stream drawn from a small symbol set so repeats are common and the
    // match lands deep in the stream, or never comes. Bytes past the match
    // exercise the ignore path. Rarely the restart is left off.
    task automatic run_stream(input int unsigned w);
        logic [7:0]  palette [$];
        int unsigned set_size;
        int unsigned len;
        logic        open_flag;
        set_size  = $urandom_range((w > 2) ? w - 2 : 1, w + 3);
        len       = $urandom_range(1, 3 * w + 4);
        open_flag = ($urandom_range(19) != 0);
        repeat (set_size) palette.push_back(8'($urandom_range(255)));
        for (int unsigned i = 0; i < len; i++)
            send_byte(palette[$urandom_range(set_size - 1)],
                      (i == 0) ? open_flag : 1'b0, (i == len - 1));
    endtask

    // A short burst with random bytes and random control bits.
    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0),
                      ($urandom_range(3) == 0));
    endtask

    initial begin
        logic [CFG_W-1:0] phase_len [NUM_PHASES] =
            '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd5, 5'd3, 5'd12};
        int unsigned w;
        int          goal;
        bit          paused;
        paused = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- Directed part, window_len at its reset value of 4 ----
        // First stream right after reset, no restart: match at byte 5.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        // After a report, even a last byte is ignored.
        send_byte(8'h12, 1'b0, 1'b1);
        // Stream ends without a match.
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        // Restart and last byte on the same beat.
        send_byte(8'h80, 1'b1, 1'b1);
        // Match on the last byte: one report only.
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h20, 1'b0, 1'b0);
        send_byte(8'h30, 1'b0, 1'b0);
        send_byte(8'h40, 1'b0, 1'b1);
        // Restart in the middle of an open stream.
        send_byte(8'h07, 1'b1, 1'b0);
        send_byte(8'h08, 1'b1, 1'b0);
        send_byte(8'h09, 1'b0, 1'b0);
        send_byte(8'h0A, 1'b0, 1'b0);
        send_byte(8'h0B, 1'b0, 1'b0);
        // Change window_len mid-stream: the open stream keeps 4.
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        set_window(5'd2);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h04, 1'b0, 1'b0);
        // The next stream picks up the new length.
        send_byte(8'h05, 1'b1, 1'b0);
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(8'h06, 1'b0, 1'b0);

        // ---- Random part, one phase per window setting ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_window(phase_len[p]);
            w = (phase_len[p] == 0) ? 1 :
                (phase_len[p] > WINDOW_MAX) ? WINDOW_MAX : phase_len[p];
            calm <= (p == 2);
            if (p == 4) begin
                // Hold off the receiver while single-byte streams pour in,
                // so the queue fills and s_tready drops.
                rx_stall_req <= 1'b1;
                repeat (24) send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            goal = bytes_used + RANDOM_BYTES / NUM_PHASES;
            while (bytes_used < goal) begin
                if ($urandom_range(9) == 0)
                    noise_burst();
                else
                    run_stream(w);
                // Pause the sender once mid-phase until the core drains.
                if (p == 6 && !paused && bytes_used > goal - 35) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/swdd_pkg.sv
hw/rtl/swdd_front.sv
hw/rtl/swdd_queue.sv
hw/rtl/swdd_back.sv
hw/rtl/sliding_window_distinct_detect_core.sv
hw/rtl/swdd_checker.sv
sim/distinct_detect_checker.sv
sim/tb_sliding_window_distinct_detect_core.sv
